// ----- design/bmp_rgb24_row_to_gray_top_defines.svh -----
// Assertion macros for the bitmap-to-gray block.
`ifndef BMP_RGB24_ROW_TO_GRAY_TOP_DEFINES_SVH
`define BMP_RGB24_ROW_TO_GRAY_TOP_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define BMP2G_ASSERT_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bmp2g check failed");

// Check that an antecedent implies a consequent in the same cycle.
`define BMP2G_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmp2g check failed");

`endif

// ----- design/bmp2g_pkg.sv -----
// Package: widths, luma weights, register codes and shared types of the bitmap-to-gray block.
package bmp2g_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 13;
	localparam int COL_W  = 12;
	localparam int ROW_W  = 12;
	localparam int CNT_W  = $clog2(MAX_WIDTH) + 1;
	localparam int RCNT_W = $clog2(MAX_HEIGHT);
	localparam int WGT_W  = 16;
	localparam int SUM_W  = WGT_W + PIX_W;

	localparam logic [WGT_W-1:0] WEIGHT_RED   = WGT_W'(19595);
	localparam logic [WGT_W-1:0] WEIGHT_GREEN = WGT_W'(38470);
	localparam logic [WGT_W-1:0] WEIGHT_BLUE  = WGT_W'(7471);

	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		PH_BLUE,
		PH_GREEN,
		PH_RED
	} phase_t;

	typedef struct packed {
		logic [PIX_W-1:0] gray;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] min_val;
		logic [PIX_W-1:0] max_val;
		logic             last;
	} pix_info_t;

endpackage

// ----- design/bmp2g_luma.sv -----
// Fixed-point luma: weighted sum of red, green and blue, top byte kept.
module bmp2g_luma (
	input  logic [bmp2g_pkg::PIX_W-1:0] red,
	input  logic [bmp2g_pkg::PIX_W-1:0] green,
	input  logic [bmp2g_pkg::PIX_W-1:0] blue,
	output logic [bmp2g_pkg::PIX_W-1:0] gray
);

	logic [bmp2g_pkg::SUM_W-1:0] prod_r;
	logic [bmp2g_pkg::SUM_W-1:0] prod_g;
	logic [bmp2g_pkg::SUM_W-1:0] prod_b;
	logic [bmp2g_pkg::SUM_W-1:0] sum;

	always_comb begin
		prod_r = bmp2g_pkg::SUM_W'(bmp2g_pkg::WEIGHT_RED) * bmp2g_pkg::SUM_W'(red);
		prod_g = bmp2g_pkg::SUM_W'(bmp2g_pkg::WEIGHT_GREEN) * bmp2g_pkg::SUM_W'(green);
		prod_b = bmp2g_pkg::SUM_W'(bmp2g_pkg::WEIGHT_BLUE) * bmp2g_pkg::SUM_W'(blue);
		sum    = prod_r + prod_g + prod_b;
		gray   = sum[bmp2g_pkg::SUM_W-1 -: bmp2g_pkg::PIX_W];
	end

endmodule

// ----- design/bmp2g_ctrl.sv -----
// Stream control: byte phase, color holds, column/row/pad counters and running extremes.
module bmp2g_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           restart,
	input  logic                           step,
	input  logic [bmp2g_pkg::PIX_W-1:0]    cur_byte,
	input  logic [bmp2g_pkg::PIX_W-1:0]    gray,
	input  logic [bmp2g_pkg::DIM_W-1:0]    width_raw,
	input  logic [bmp2g_pkg::DIM_W-1:0]    height_raw,
	output logic                           is_red,
	output logic [bmp2g_pkg::PIX_W-1:0]    blue_out,
	output logic [bmp2g_pkg::PIX_W-1:0]    green_out,
	output bmp2g_pkg::pix_info_t           info
);

	bmp2g_pkg::phase_t               phase_q;
	logic [bmp2g_pkg::PIX_W-1:0]     blue_q;
	logic [bmp2g_pkg::PIX_W-1:0]     green_q;
	logic [bmp2g_pkg::CNT_W-1:0]     col_q;
	logic [bmp2g_pkg::RCNT_W-1:0]    row_q;
	logic [1:0]                      pad_q;
	logic [bmp2g_pkg::PIX_W-1:0]     min_q;
	logic [bmp2g_pkg::PIX_W-1:0]     max_q;

	logic [bmp2g_pkg::DIM_W-1:0]     w_eff;
	logic [bmp2g_pkg::DIM_W-1:0]     h_eff;
	logic [1:0]                      pads;
	logic                            is_pad;
	logic [bmp2g_pkg::CNT_W-1:0]     col_inc;
	logic [bmp2g_pkg::DIM_W-1:0]     row_inc;
	logic [bmp2g_pkg::RCNT_W-1:0]    row_wrap;
	logic                            col_last;
	logic                            row_last;
	logic                            last;
	logic [1:0]                      pad_inc;
	logic [bmp2g_pkg::DIM_W-1:0]     top_row;
	logic [bmp2g_pkg::PIX_W-1:0]     min_new;
	logic [bmp2g_pkg::PIX_W-1:0]     max_new;

	always_comb begin
		priority if (width_raw == '0) begin
			w_eff = bmp2g_pkg::DIM_W'(1);
		end else if (width_raw > bmp2g_pkg::DIM_W'(bmp2g_pkg::MAX_WIDTH)) begin
			w_eff = bmp2g_pkg::DIM_W'(bmp2g_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_raw;
		end
		priority if (height_raw == '0) begin
			h_eff = bmp2g_pkg::DIM_W'(1);
		end else if (height_raw > bmp2g_pkg::DIM_W'(bmp2g_pkg::MAX_HEIGHT)) begin
			h_eff = bmp2g_pkg::DIM_W'(bmp2g_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_raw;
		end
		pads     = w_eff[1:0];
		is_pad   = bmp2g_pkg::DIM_W'(col_q) >= w_eff;
		is_red   = !is_pad && (phase_q == bmp2g_pkg::PH_RED);
		col_inc  = col_q + bmp2g_pkg::CNT_W'(1);
		row_inc  = bmp2g_pkg::DIM_W'(row_q) + bmp2g_pkg::DIM_W'(1);
		col_last = bmp2g_pkg::DIM_W'(col_inc) >= w_eff;
		row_last = row_inc >= h_eff;
		row_wrap = row_last ? '0 : row_inc[bmp2g_pkg::RCNT_W-1:0];
		last     = col_last && row_last;
		pad_inc  = pad_q + 2'd1;
		top_row  = h_eff - bmp2g_pkg::DIM_W'(1) - bmp2g_pkg::DIM_W'(row_q);
		min_new  = (gray < min_q) ? gray : min_q;
		max_new  = (gray > max_q) ? gray : max_q;

		blue_out     = blue_q;
		green_out    = green_q;
		info.gray    = gray;
		info.column  = col_q[bmp2g_pkg::COL_W-1:0];
		info.row     = top_row[bmp2g_pkg::ROW_W-1:0];
		info.min_val = min_new;
		info.max_val = max_new;
		info.last    = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmp2g_pkg::PH_BLUE;
			blue_q  <= '0;
			green_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pad_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (restart) begin
			phase_q <= bmp2g_pkg::PH_BLUE;
			blue_q  <= '0;
			green_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pad_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (step) begin
			if (is_pad) begin
				pad_q <= pad_inc;
				if (pad_inc >= pads) begin
					col_q <= '0;
					pad_q <= '0;
					row_q <= row_wrap;
				end
			end else begin
				unique case (phase_q)
					bmp2g_pkg::PH_BLUE: begin
						blue_q  <= cur_byte;
						phase_q <= bmp2g_pkg::PH_GREEN;
					end
					bmp2g_pkg::PH_GREEN: begin
						green_q <= cur_byte;
						phase_q <= bmp2g_pkg::PH_RED;
					end
					bmp2g_pkg::PH_RED: begin
						phase_q <= bmp2g_pkg::PH_BLUE;
						if (last) begin
							min_q <= '1;
							max_q <= '0;
						end else begin
							min_q <= min_new;
							max_q <= max_new;
						end
						if (col_last && (pads == 2'd0)) begin
							col_q <= '0;
							pad_q <= '0;
							row_q <= row_wrap;
						end else begin
							col_q <= col_inc;
						end
					end
					default: begin
						phase_q <= bmp2g_pkg::PH_BLUE;
					end
				endcase
			end
		end
	end

endmodule

// ----- design/bmp_rgb24_row_to_gray_top.sv -----
// Top level: 24-bit bitmap pixel byte stream to 8-bit gray with position and extremes.
//
// Input channel: one pixel-data byte per transfer (in_valid / in_stall), blue,
// green, red order, row pad bytes included. Output channel (out_valid /
// out_stall): one result per red byte with gray value, column, top-down row,
// running min and max, and a last-pixel flag. Blue, green and pad bytes give
// no result.
// A red byte's result passes the input register, then the result register,
// which raises out_valid.
// Throughput: one byte per cycle while no red byte waits on a stalled receiver;
// the luma multiply-add and the counter update sit between these two registers.
// When the receiver stalls, the result register holds; the input register
// still drains non-red bytes, and a red byte waits in it, which raises in_stall.
// Reset: image size 640 x 480, stream restarts at a blue byte, column 0,
// stored row 0. A write to either size register restarts the stream the same
// way; write only while no transfer is in flight.
`include "bmp_rgb24_row_to_gray_top_defines.svh"

module bmp_rgb24_row_to_gray_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bmp2g_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmp2g_pkg::DIM_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bmp2g_pkg::PIX_W-1:0]       data_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bmp2g_pkg::PIX_W-1:0]       gray_value,
	output logic [bmp2g_pkg::COL_W-1:0]       column,
	output logic [bmp2g_pkg::ROW_W-1:0]       row,
	output logic [bmp2g_pkg::PIX_W-1:0]       min_so_far,
	output logic [bmp2g_pkg::PIX_W-1:0]       max_so_far,
	output logic                              last_pixel
);

	logic [bmp2g_pkg::DIM_W-1:0] width_q;
	logic [bmp2g_pkg::DIM_W-1:0] height_q;
	logic                        valid_s1;
	logic [bmp2g_pkg::PIX_W-1:0] byte_s1;
	logic                        valid_s2;
	bmp2g_pkg::pix_info_t        info_s2;

	logic                        is_red;
	logic [bmp2g_pkg::PIX_W-1:0] blue_hold;
	logic [bmp2g_pkg::PIX_W-1:0] green_hold;
	logic [bmp2g_pkg::PIX_W-1:0] gray;
	bmp2g_pkg::pix_info_t        info;
	logic                        out_free;
	logic                        s1_adv;
	logic                        in_take;

	always_comb begin
		out_free = !valid_s2 || !out_stall;
		s1_adv   = valid_s1 && (!is_red || out_free);
		in_stall = valid_s1 && !s1_adv;
		in_take  = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmp2g_pkg::WIDTH_RESET;
			height_q <= bmp2g_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmp2g_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bmp2g_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv && is_red) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
		if (s1_adv && is_red) begin
			info_s2 <= info;
		end
	end

	bmp2g_luma u_luma (
		.red   (byte_s1),
		.green (green_hold),
		.blue  (blue_hold),
		.gray  (gray)
	);

	bmp2g_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.step       (s1_adv),
		.cur_byte   (byte_s1),
		.gray       (gray),
		.width_raw  (width_q),
		.height_raw (height_q),
		.is_red     (is_red),
		.blue_out   (blue_hold),
		.green_out  (green_hold),
		.info       (info)
	);

	assign out_valid  = valid_s2;
	assign gray_value = info_s2.gray;
	assign column     = info_s2.column;
	assign row        = info_s2.row;
	assign min_so_far = info_s2.min_val;
	assign max_so_far = info_s2.max_val;
	assign last_pixel = info_s2.last;

	`BMP2G_ASSERT_IMPLIES(a_stall_needs_s1, in_stall, valid_s1 && is_red)
	`BMP2G_ASSERT_IMPLIES(a_min_le_gray, out_valid, min_so_far <= gray_value)
	`BMP2G_ASSERT_IMPLIES(a_gray_le_max, out_valid, gray_value <= max_so_far)
	`BMP2G_ASSERT_HOLDS(a_no_stall_when_free, !(in_stall && out_free))

endmodule
